FILE: hw/rtl/assert_macros.svh
// Assertion helper macros used by the checker file.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, disabled while reset is active.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: hw/rtl/sq12_pkg.sv
// Shared types and constants for the signed Q12 fixed-point divider.
// No dependencies; used by every RTL file of the divider.
package sq12_pkg;

    localparam int WORD_W          = 32;
    // restoring steps done between two pipeline registers
    localparam int STEPS_PER_STAGE = 4;

    typedef struct packed {
        logic signed [WORD_W-1:0] dividend;
        logic signed [WORD_W-1:0] divisor;
    } operands_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] quotient;
        logic                     zero_divisor;
    } result_t;

    // control travelling alongside the datapath of each pipeline stage
    typedef struct packed {
        logic valid;
        logic negate;
        logic zero_div;
    } ctl_t;

endpackage

FILE: hw/rtl/sq12_prep.sv
// Input stage: operand magnitudes, sign of result and zero-divisor flag.
// Depends on sq12_pkg.
module sq12_prep #(
    parameter int FRACTION_BITS = 12,
    parameter int PAD_W         = 44
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  sq12_pkg::operands_t           operands,
    output sq12_pkg::ctl_t                ctl,
    output logic [PAD_W-1:0]              num,
    output logic [sq12_pkg::WORD_W-1:0]   den
);

    localparam int W = sq12_pkg::WORD_W;

    sq12_pkg::ctl_t     ctl_reg, ctl_next;
    logic [PAD_W-1:0]   num_reg, num_next;
    logic [W-1:0]       den_reg, den_next;
    logic [W-1:0]       mag_n, mag_d;

    always_comb
    begin
        // most negative value maps to 2^31 as an unsigned magnitude
        mag_n = operands.dividend[W-1] ? (W'(0) - W'(operands.dividend))
                                       : W'(operands.dividend);
        mag_d = operands.divisor[W-1]  ? (W'(0) - W'(operands.divisor))
                                       : W'(operands.divisor);
        num_next          = {{(PAD_W-W){1'b0}}, mag_n} << FRACTION_BITS;
        den_next          = mag_d;
        ctl_next.valid    = load;
        ctl_next.negate   = operands.dividend[W-1] ^ operands.divisor[W-1];
        ctl_next.zero_div = (mag_d == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign ctl = ctl_reg;
    assign num = num_reg;
    assign den = den_reg;

endmodule

FILE: hw/rtl/sq12_div_stage.sv
// One pipeline stage of the restoring divider: STEPS_PER_STAGE quotient bits.
// Depends on sq12_pkg.
module sq12_div_stage #(
    parameter int PAD_W = 44
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sq12_pkg::ctl_t                ctl_in,
    input  logic [PAD_W-1:0]              num_in,
    input  logic [sq12_pkg::WORD_W-1:0]   den_in,
    input  logic [sq12_pkg::WORD_W-1:0]   rem_in,
    input  logic [sq12_pkg::WORD_W-1:0]   quo_in,
    output sq12_pkg::ctl_t                ctl_out,
    output logic [PAD_W-1:0]              num_out,
    output logic [sq12_pkg::WORD_W-1:0]   den_out,
    output logic [sq12_pkg::WORD_W-1:0]   rem_out,
    output logic [sq12_pkg::WORD_W-1:0]   quo_out
);

    localparam int W = sq12_pkg::WORD_W;
    localparam int K = sq12_pkg::STEPS_PER_STAGE;

    sq12_pkg::ctl_t     ctl_reg;
    logic [PAD_W-1:0]   num_reg, num_next;
    logic [W-1:0]       den_reg;
    logic [W-1:0]       rem_reg, rem_next;
    logic [W-1:0]       quo_reg, quo_next;
    logic [W:0]         trial, diff;

    // remainder stays below the divisor, so trial < 2*den fits W+1 bits
    always_comb
    begin
        rem_next = rem_in;
        num_next = num_in;
        quo_next = quo_in;
        trial    = '0;
        diff     = '0;
        for (int i = 0; i < K; i++)
        begin
            trial    = {rem_next, num_next[PAD_W-1]};
            num_next = num_next << 1;
            diff     = trial - {1'b0, den_in};
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_next[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_next[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_in;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign ctl_out = ctl_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

FILE: hw/rtl/sq12_post.sv
// Output stage: applies the result sign and the zero-divisor override.
// Depends on sq12_pkg.
module sq12_post (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sq12_pkg::ctl_t                ctl,
    input  logic [sq12_pkg::WORD_W-1:0]   quo,
    output logic                          done,
    output sq12_pkg::result_t             result
);

    localparam int W = sq12_pkg::WORD_W;

    logic                 done_reg;
    sq12_pkg::result_t    result_reg, result_next;

    always_comb
    begin
        if (ctl.zero_div)
        begin
            result_next.quotient = '0;
        end
        else if (ctl.negate)
        begin
            result_next.quotient = $signed(W'(0) - quo);
        end
        else
        begin
            result_next.quotient = $signed(quo);
        end
        result_next.zero_divisor = ctl.zero_div;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hw/rtl/signed_q12_fixed_point_divider_unit.sv
// Signed fixed-point divider: quotient = trunc(dividend * 2^FRACTION_BITS / divisor), low 32 bits.
// Registered pipeline: input stage, restoring-divider stages that each retire four quotient
// bits, then the output stage.
// Throughput: one transaction per cycle; busy is always low, done pulses once per transaction.
// Reset clears only the stage control bits and done; in-flight transactions are dropped.
// Depends on sq12_pkg, sq12_prep, sq12_div_stage, sq12_post.
module signed_q12_fixed_point_divider_unit #(
    parameter int FRACTION_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sq12_pkg::operands_t  operands,
    output logic                 done,
    output sq12_pkg::result_t    result
);

    localparam int W      = sq12_pkg::WORD_W;
    localparam int K      = sq12_pkg::STEPS_PER_STAGE;
    localparam int NUM_W  = W + FRACTION_BITS;
    localparam int STAGES = (NUM_W + K - 1) / K;
    localparam int PAD_W  = STAGES * K;

    sq12_pkg::ctl_t     ctl_chain [STAGES+1];
    logic [PAD_W-1:0]   num_chain [STAGES+1];
    logic [W-1:0]       den_chain [STAGES+1];
    logic [W-1:0]       rem_chain [STAGES+1];
    logic [W-1:0]       quo_chain [STAGES+1];

    assign busy = 1'b0;

    sq12_prep #(
        .FRACTION_BITS (FRACTION_BITS),
        .PAD_W         (PAD_W)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (start),
        .operands (operands),
        .ctl      (ctl_chain[0]),
        .num      (num_chain[0]),
        .den      (den_chain[0])
    );

    assign rem_chain[0] = '0;
    assign quo_chain[0] = '0;

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        sq12_div_stage #(
            .PAD_W (PAD_W)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_chain[s]),
            .num_in  (num_chain[s]),
            .den_in  (den_chain[s]),
            .rem_in  (rem_chain[s]),
            .quo_in  (quo_chain[s]),
            .ctl_out (ctl_chain[s+1]),
            .num_out (num_chain[s+1]),
            .den_out (den_chain[s+1]),
            .rem_out (rem_chain[s+1]),
            .quo_out (quo_chain[s+1])
        );
    end

    sq12_post u_post (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_chain[STAGES]),
        .quo    (quo_chain[STAGES]),
        .done   (done),
        .result (result)
    );

endmodule

FILE: hw/rtl/sq12_checker.sv
// Port-level checks for the signed Q12 divider, bound to the top level.
// Depends on sq12_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sq12_checker #(
    parameter int FRACTION_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  sq12_pkg::operands_t  operands,
    input  logic                 done,
    input  sq12_pkg::result_t    result
);

    localparam int K       = sq12_pkg::STEPS_PER_STAGE;
    localparam int LATENCY = 2 + (sq12_pkg::WORD_W + FRACTION_BITS + K - 1) / K;

    // every result traces back to a transaction a fixed latency earlier
    `ASSERT_IMPLY(a_done_has_start, clk, rst_n, done, $past(start && !busy, LATENCY))

    `ASSERT_IMPLY(a_zero_flag_match, clk, rst_n, done,
        result.zero_divisor == $past(operands.divisor == '0, LATENCY))

    `ASSERT_IMPLY(a_zero_flag_quot, clk, rst_n, done && result.zero_divisor,
        result.quotient == '0)

    `ASSERT_IMPLY(a_zero_dividend, clk, rst_n,
        done && $past(operands.dividend == '0, LATENCY), result.quotient == '0)

endmodule

bind signed_q12_fixed_point_divider_unit sq12_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_sq12_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .done     (done),
    .result   (result)
);

FILE: bench/tb.sv
// Self-checking bench for signed_q12_fixed_point_divider_unit: directed corner operands,
// then random operands, with every result checked against an in-bench Q12 divider model.
// Depends on sq12_pkg and the divider RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRACTION_BITS = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 30;       // longer than the pipeline latency
    localparam int PRINT_CAP     = 200;

    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MINUS_1  = 32'hFFFF_FFFF;

    typedef struct packed {
        sq12_pkg::operands_t op;
        sq12_pkg::result_t   want;
    } div_check_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    sq12_pkg::operands_t operands;
    logic                done;
    sq12_pkg::result_t   result;

    sq12_pkg::operands_t operand_queue[$];
    div_check_t          results_due[$];

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  checked_count  = 0;
    int  zero_div_count = 0;
    int  negative_count = 0;
    bit  no_gaps        = 0;

    signed_q12_fixed_point_divider_unit #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operands(operands),
        .done    (done),
        .result  (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Q12 division on magnitudes, low 32 bits kept, sign applied modulo 2^32
    function automatic sq12_pkg::result_t divide_q12(sq12_pkg::operands_t op);
        logic [31:0]       num_mag;
        logic [31:0]       den_mag;
        logic [63:0]       scaled;
        logic [31:0]       quo;
        sq12_pkg::result_t r;
        num_mag = op.dividend[31] ? (~op.dividend + 32'd1) : op.dividend;
        den_mag = op.divisor[31]  ? (~op.divisor + 32'd1)  : op.divisor;
        if (den_mag == 32'd0)
        begin
            r.quotient     = '0;
            r.zero_divisor = 1'b1;
            return r;
        end
        scaled = {32'd0, num_mag} << FRACTION_BITS;
        quo    = 32'(scaled / {32'd0, den_mag});
        if (op.dividend[31] ^ op.divisor[31])
            quo = ~quo + 32'd1;
        r.quotient     = quo;
        r.zero_divisor = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3, 4:    v = $urandom >> $urandom_range(0, 31);
            5, 6:    v = $urandom_range(0, 4096);
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       v = MOST_NEG;
                    1:       v = MOST_POS;
                    2:       v = 32'd1;
                    default: v = MINUS_1;
                endcase
            end
            8:       v = $urandom_range(0, 1) ? MOST_NEG + $urandom_range(0, 15)
                                              : MOST_POS - $urandom_range(0, 15);
            default: v = '0;
        endcase
        // random sign on every pick but MOST_NEG and MOST_POS
        if (v != MOST_NEG && v != MOST_POS && $urandom_range(0, 1))
            v = ~v + 32'd1;
        return v;
    endfunction

    task automatic queue_item(input logic [31:0] num, input logic [31:0] den);
        sq12_pkg::operands_t op;
        op.dividend = num;
        op.divisor  = den;
        operand_queue.push_back(op);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            queue_item(pick_operand(), pick_operand());
    endtask

    task automatic wait_drained();
        while (operand_queue.size() != 0 || results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        // keep the log bounded when a lot goes wrong
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // driver: presents the oldest pending transaction, idling at random unless no_gaps is set
    always @(negedge clk)
    begin
        if (!rst_n || operand_queue.size() == 0 ||
            (!no_gaps && $urandom_range(0, 99) < 25))
        begin
            start <= 1'b0;
        end
        else
        begin
            start    <= 1'b1;
            operands <= operand_queue[0];
        end
    end

    // monitor: check results first, then record any transaction accepted at this edge
    always @(posedge clk)
    begin
        div_check_t due;
        div_check_t entry;
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                report_mismatch($sformatf("result %h/%b with no transaction outstanding",
                                          result.quotient, result.zero_divisor));
            end
            else
            begin
                due = results_due.pop_front();
                checked_count++;
                if (due.want.zero_divisor)
                    zero_div_count++;
                if (due.want.quotient[31])
                    negative_count++;
                if (result.quotient !== due.want.quotient)
                    report_mismatch($sformatf("%h / %h: quotient %h, want %h",
                                              due.op.dividend, due.op.divisor,
                                              result.quotient, due.want.quotient));
                if (result.zero_divisor !== due.want.zero_divisor)
                    report_mismatch($sformatf("%h / %h: zero_divisor %b, want %b",
                                              due.op.dividend, due.op.divisor,
                                              result.zero_divisor,
                                              due.want.zero_divisor));
            end
        end
        if (rst_n && start && !busy)
        begin
            entry.op   = operands;
            entry.want = divide_q12(operands);
            results_due.push_back(entry);
            void'(operand_queue.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        operands = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corners: extremes, all sign combinations, wrap, zero divisor
        queue_item(32'd0, 32'd1);
        queue_item(32'd1, 32'd1);
        queue_item(MOST_NEG, 32'd1);
        queue_item(MOST_NEG, MINUS_1);
        queue_item(MOST_NEG, MOST_NEG);
        queue_item(MOST_POS, MOST_NEG);
        queue_item(MOST_POS, MOST_POS);
        queue_item(MOST_POS, 32'd1);
        queue_item(MOST_POS, MINUS_1);
        queue_item(MINUS_1, MOST_POS);
        queue_item(32'h0008_0000, 32'd1);     // 2^31 magnitude lands on the sign bit
        queue_item(32'h0010_0000, 32'd1);     // 2^32 wraps to zero
        queue_item(32'hFFF8_0000, 32'd1);
        queue_item(32'd7, 32'd2);
        queue_item(-32'sd7, 32'd2);
        queue_item(32'd7, -32'sd2);
        queue_item(-32'sd7, -32'sd2);
        queue_item(32'd1, 32'd3);
        queue_item(MINUS_1, 32'd3);
        queue_item(32'd5, 32'd0);
        queue_item(MOST_NEG, 32'd0);
        queue_item(32'd0, 32'd0);
        queue_item(MOST_POS, 32'd4096);
        queue_item(32'hAAAA_AAAA, 32'h5555_5555);
        queue_item(32'h5555_5555, 32'hAAAA_AAAA);
        wait_drained();

        queue_random(500);
        // sender holds off until the pipeline is empty
        wait_drained();

        no_gaps = 1'b1;
        queue_random(400);
        wait_drained();
        no_gaps = 1'b0;

        queue_random(500);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));
        $display("Checked %0d divisions (%0d by zero, %0d negative quotients)",
                 checked_count, zero_div_count, negative_count);
        $display("Covered operand extremes, quotient wrap, back-to-back and gapped issue");
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/sq12_pkg.sv
hw/rtl/sq12_prep.sv
hw/rtl/sq12_div_stage.sv
hw/rtl/sq12_post.sv
hw/rtl/signed_q12_fixed_point_divider_unit.sv
hw/rtl/sq12_checker.sv
bench/tb.sv
